// ----- rtl/plni_pkg.sv -----
// Shared constants and types of the periodic lattice neighbour index unit.
package plni_pkg;

	localparam int AXES = 4;
	localparam int SITE_W = 24;
	localparam int COORD_W = 6;
	localparam int SHIFT_W = 8;
	localparam int EXT_W = 7;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 48;
	// Request kind, coordinates and shifts as they ride beside the index dividers.
	localparam int SIDE_W = 1 + AXES * (COORD_W + SHIFT_W);
	localparam int DIV_STAGES = 3;
	localparam int PIPE_STAGES = 19;
	localparam logic [EXT_W-1:0] EXT_RESET = 7'd16;

	typedef enum logic [1:0] {
		REG_EXTENT_X = 2'd0,
		REG_EXTENT_Y = 2'd1,
		REG_EXTENT_Z = 2'd2,
		REG_EXTENT_T = 2'd3
	} reg_idx_t;

endpackage

// ----- rtl/plni_div.sv -----
// Three-stage divider by a small run-time divisor, using a reciprocal table.
module plni_div #(
	parameter int NW = 24,
	parameter int DW = 7,
	parameter int RW = 6,
	parameter int PW = 1
) (
	input  logic                            clk,
	input  logic [plni_pkg::DIV_STAGES-1:0] en,
	input  logic [NW-1:0]                   num,
	input  logic [DW-1:0]                   den,
	input  logic [PW-1:0]                   side_in,
	output logic [NW-1:0]                   quot,
	output logic [RW-1:0]                   rem,
	output logic [PW-1:0]                   side_out
);

	localparam int TD = 2 ** DW;

	logic [NW:0]       recip_tab [TD];
	logic [2*NW:0]     prod_s1;
	logic [NW-1:0]     num_s1;
	logic [PW-1:0]     side_s1;
	logic [NW-1:0]     q_est;
	logic [NW+DW-1:0]  qd_full;
	logic [NW-1:0]     q_s2;
	logic [NW-1:0]     qd_s2;
	logic [NW-1:0]     num_s2;
	logic [PW-1:0]     side_s2;
	logic [NW-1:0]     diff;
	logic [NW-1:0]     diff_red;
	logic              big;
	logic [NW-1:0]     q_s3;
	logic [RW-1:0]     r_s3;
	logic [PW-1:0]     side_s3;

	// Reciprocal floor(2^NW / d); the estimate it gives is never more than one low.
	for (genvar g = 0; g < TD; g++) begin : g_rc
		localparam logic [NW:0] RC = (NW+1)'((64'd1 << NW) / ((g == 0) ? 1 : g));
		assign recip_tab[g] = (g == 0) ? '0 : RC;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= (2*NW+1)'(num) * (2*NW+1)'(recip_tab[den]);
			num_s1  <= num;
			side_s1 <= side_in;
		end
	end

	assign q_est   = prod_s1[2*NW-1:NW];
	assign qd_full = (NW+DW)'(q_est) * (NW+DW)'(den);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s2    <= q_est;
			qd_s2   <= qd_full[NW-1:0];
			num_s2  <= num_s1;
			side_s2 <= side_s1;
		end
	end

	assign diff     = num_s2 - qd_s2;
	assign big      = diff >= NW'(den);
	assign diff_red = diff - NW'(den);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			q_s3    <= big ? q_s2 + NW'(1) : q_s2;
			r_s3    <= big ? diff_red[RW-1:0] : diff[RW-1:0];
			side_s3 <= side_s2;
		end
	end

	assign quot     = q_s3;
	assign rem      = r_s3;
	assign side_out = side_s3;

endmodule

// ----- rtl/periodic_lattice_neighbor_index_unit.sv -----
// Top level of the periodic lattice neighbour index unit.
//
// The unit takes one request per clock cycle while s_tready is high and
// returns one result per request, in order. A request names a 4-D site
// either as a linear index (x fastest, then y, z, t) or as four coordinates,
// together with a signed shift per axis. A linear index is split into
// coordinates by four chained divider units (three stages each, stages 1 to 12),
// each dividing by one extent through a reciprocal table, a multiply and a
// single correction step. Stage 13 selects the coordinates, adds
// the shifts and raises out_of_range for a site outside the lattice or a shift
// larger than its extent. Stages 14 to 16 reduce each shifted coordinate modulo
// its extent in four parallel dividers, so that even an oversized shift wraps
// fully. Stages 17 to 19 rebuild the linear index by Horner's rule and form the
// output register. Each stage holds its own valid bit and advances whenever it
// is empty or the stage after it advances, so a stalled output does not stop
// the upstream stages from filling. Extent registers that hold zero count as
// one, values above MAX_EXTENT count as MAX_EXTENT. There is no state other
// than the extents and the pipeline registers, and no clearing pass after reset.
module periodic_lattice_neighbor_index_unit #(
	parameter int MAX_EXTENT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [1:0]                       cfg_index,
	input  logic [plni_pkg::EXT_W-1:0]       cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// site_index[23:0], coord_x, coord_y, coord_z, coord_t, shift_x, shift_y,
	// shift_z, shift_t
	input  logic [plni_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// new_index[23:0], new_x, new_y, new_z, new_t
	output logic [plni_pkg::OUT_DATA_W-1:0]  m_tdata,
	// out_of_range
	output logic                             m_tuser
);

	localparam int NS   = plni_pkg::PIPE_STAGES;
	localparam int IW   = plni_pkg::SITE_W;
	localparam int EW   = $clog2(MAX_EXTENT + 1);
	localparam int CW   = (MAX_EXTENT > 2) ? $clog2(MAX_EXTENT) : 1;
	localparam int CIW  = (CW > plni_pkg::COORD_W) ? CW : plni_pkg::COORD_W;
	localparam int SUMW = ((CIW > 7) ? CIW : 7) + 2;
	localparam int SW   = plni_pkg::SIDE_W;
	localparam int HW   = IW + EW;

	// Extent registers and their effective values.
	logic [plni_pkg::EXT_W-1:0] ext_q [plni_pkg::AXES];
	logic [EW-1:0]              ext_eff [plni_pkg::AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < plni_pkg::AXES; j++) begin
				ext_q[j] <= plni_pkg::EXT_RESET;
			end
		end else if (cfg_wen) begin
			case (plni_pkg::reg_idx_t'(cfg_index))
				plni_pkg::REG_EXTENT_X: ext_q[0] <= cfg_wdata;
				plni_pkg::REG_EXTENT_Y: ext_q[1] <= cfg_wdata;
				plni_pkg::REG_EXTENT_Z: ext_q[2] <= cfg_wdata;
				plni_pkg::REG_EXTENT_T: ext_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < plni_pkg::AXES; j++) begin
			if (ext_q[j] == '0) begin
				ext_eff[j] = EW'(1);
			end else if (int'(ext_q[j]) > MAX_EXTENT) begin
				ext_eff[j] = EW'(MAX_EXTENT);
			end else begin
				ext_eff[j] = EW'(ext_q[j]);
			end
		end
	end

	// Valid bits and per-stage advance. A stage loads when it is empty or its
	// contents move on in the same cycle.
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;
	logic [NS:0]   vld_in;

	assign en[NS+1] = m_tready;
	for (genvar k = 1; k <= NS; k++) begin : g_en
		assign en[k] = ~vld_q[k] | en[k+1];
	end
	assign vld_in = {vld_q, s_tvalid};
	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k-1];
				end
			end
		end
	end

	// Stages 1 to 12: the linear index is divided by each extent in turn. The
	// remainders are the coordinates; a non-zero last quotient means the index
	// lies beyond the lattice volume.
	logic [IW-1:0]     q1, q2, q3, q4;
	logic [CW-1:0]     r0, r1, r2, r3;
	logic [SW-1:0]     side1;
	logic [SW+CW-1:0]  side2;
	logic [SW+2*CW-1:0] side3;
	logic [SW+3*CW-1:0] side4;

	plni_div #(.NW(IW), .DW(EW), .RW(CW), .PW(SW)) u_div_x (
		.clk(clk), .en(en[3:1]), .num(s_tdata[IW-1:0]), .den(ext_eff[0]),
		.side_in({s_tuser, s_tdata[plni_pkg::IN_DATA_W-1:IW]}),
		.quot(q1), .rem(r0), .side_out(side1)
	);

	plni_div #(.NW(IW), .DW(EW), .RW(CW), .PW(SW+CW)) u_div_y (
		.clk(clk), .en(en[6:4]), .num(q1), .den(ext_eff[1]),
		.side_in({side1, r0}), .quot(q2), .rem(r1), .side_out(side2)
	);

	plni_div #(.NW(IW), .DW(EW), .RW(CW), .PW(SW+2*CW)) u_div_z (
		.clk(clk), .en(en[9:7]), .num(q2), .den(ext_eff[2]),
		.side_in({side2, r1}), .quot(q3), .rem(r2), .side_out(side3)
	);

	plni_div #(.NW(IW), .DW(EW), .RW(CW), .PW(SW+3*CW)) u_div_t (
		.clk(clk), .en(en[12:10]), .num(q3), .den(ext_eff[3]),
		.side_in({side3, r2}), .quot(q4), .rem(r3), .side_out(side4)
	);

	// Stage 13: pick the coordinates, add the shifts, check the ranges.
	logic [SW-1:0]   req_side;
	logic [CW-1:0]   idx_c [plni_pkg::AXES];
	logic [SUMW-1:0] mag_c [plni_pkg::AXES];
	logic [plni_pkg::AXES-1:0] neg_c;
	logic            flag_c;
	logic [SUMW-1:0] mag_s13 [plni_pkg::AXES];
	logic [plni_pkg::AXES-1:0] neg_s13;
	logic            flag_s13;

	assign req_side = side4[SW+3*CW-1:3*CW];
	assign idx_c[0] = side4[3*CW-1:2*CW];
	assign idx_c[1] = side4[2*CW-1:CW];
	assign idx_c[2] = side4[CW-1:0];
	assign idx_c[3] = r3;

	always_comb begin
		logic                        req;
		logic [plni_pkg::COORD_W-1:0] crd;
		logic [plni_pkg::SHIFT_W-1:0] shf;
		logic [CIW-1:0]              c;
		logic signed [SUMW-1:0]      sum;
		logic signed [SUMW-1:0]      sh_s;
		logic signed [SUMW-1:0]      e_s;
		req    = req_side[SW-1];
		flag_c = !req && (q4 != '0);
		for (int j = 0; j < plni_pkg::AXES; j++) begin
			crd = req_side[j*plni_pkg::COORD_W +: plni_pkg::COORD_W];
			shf = req_side[plni_pkg::AXES*plni_pkg::COORD_W + j*plni_pkg::SHIFT_W
				+: plni_pkg::SHIFT_W];
			c = req ? CIW'(crd) : CIW'(idx_c[j]);
			if (req && (int'(crd) >= int'(ext_eff[j]))) begin
				flag_c = 1'b1;
			end
			sh_s = SUMW'($signed(shf));
			e_s  = $signed(SUMW'(ext_eff[j]));
			if ((sh_s < -e_s) || (sh_s > e_s)) begin
				flag_c = 1'b1;
			end
			sum = $signed(SUMW'(c)) + sh_s;
			neg_c[j] = sum[SUMW-1];
			mag_c[j] = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			mag_s13  <= mag_c;
			neg_s13  <= neg_c;
			flag_s13 <= flag_c;
		end
	end

	// Stages 14 to 16: each shifted coordinate reduced modulo its extent.
	logic [CW-1:0] lrem [plni_pkg::AXES];
	logic [plni_pkg::AXES-1:0] lneg;
	logic flag_s14, flag_s15, flag_s16;

	for (genvar j = 0; j < plni_pkg::AXES; j++) begin : g_lane
		plni_div #(.NW(SUMW), .DW(EW), .RW(CW), .PW(1)) u_wrap (
			.clk(clk), .en(en[16:14]), .num(mag_s13[j]), .den(ext_eff[j]),
			.side_in(neg_s13[j]), .quot(), .rem(lrem[j]), .side_out(lneg[j])
		);
	end

	always_ff @(posedge clk) begin
		if (en[14]) flag_s14 <= flag_s13;
		if (en[15]) flag_s15 <= flag_s14;
		if (en[16]) flag_s16 <= flag_s15;
	end

	// Stages 17 to 19: fold negative remainders back into range and rebuild
	// the linear index as ((t * Ez + z) * Ey + y) * Ex + x.
	logic [CW-1:0] rf_c   [plni_pkg::AXES];
	logic [CW-1:0] rf_s17 [plni_pkg::AXES];
	logic [CW-1:0] rf_s18 [plni_pkg::AXES];
	logic [CW-1:0] rf_s19 [plni_pkg::AXES];
	logic [HW-1:0] h1_full, h2_full, h3_full;
	logic [IW-1:0] h_s17, h_s18, h_s19;
	logic          flag_s17, flag_s18, flag_s19;

	always_comb begin
		logic [EW-1:0] back;
		for (int j = 0; j < plni_pkg::AXES; j++) begin
			back = ext_eff[j] - EW'(lrem[j]);
			rf_c[j] = (lneg[j] && (lrem[j] != '0)) ? back[CW-1:0] : lrem[j];
		end
	end

	assign h1_full = HW'(rf_c[3]) * HW'(ext_eff[2]) + HW'(rf_c[2]);
	assign h2_full = HW'(h_s17) * HW'(ext_eff[1]) + HW'(rf_s17[1]);
	assign h3_full = HW'(h_s18) * HW'(ext_eff[0]) + HW'(rf_s18[0]);

	always_ff @(posedge clk) begin
		if (en[17]) begin
			h_s17    <= h1_full[IW-1:0];
			rf_s17   <= rf_c;
			flag_s17 <= flag_s16;
		end
		if (en[18]) begin
			h_s18    <= h2_full[IW-1:0];
			rf_s18   <= rf_s17;
			flag_s18 <= flag_s17;
		end
		if (en[19]) begin
			h_s19    <= h3_full[IW-1:0];
			rf_s19   <= rf_s18;
			flag_s19 <= flag_s18;
		end
	end

	assign m_tvalid = vld_q[NS];
	assign m_tuser  = flag_s19;
	assign m_tdata  = {plni_pkg::COORD_W'(rf_s19[3]), plni_pkg::COORD_W'(rf_s19[2]),
		plni_pkg::COORD_W'(rf_s19[1]), plni_pkg::COORD_W'(rf_s19[0]), h_s19};

	// The input can only be refused when every stage is full and the output is held.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> ((&vld_q) && !m_tready))
		else $error("input refused while the pipeline has room");

	// The last index divider must leave a time coordinate below its extent.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[12] |-> (EW'(r3) < ext_eff[3]))
		else $error("index divider remainder not below extent");

	// Every delivered coordinate lies inside its extent.
	a_out_coord: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((EW'(rf_s19[0]) < ext_eff[0]) && (EW'(rf_s19[1]) < ext_eff[1]) &&
			(EW'(rf_s19[2]) < ext_eff[2]) && (EW'(rf_s19[3]) < ext_eff[3])))
		else $error("wrapped coordinate outside its extent");

endmodule

// ----- dv/periodic_lattice_neighbor_index_unit_tb.sv -----
// Self-checking testbench for the periodic lattice neighbour index unit.
`timescale 1ns / 1ps

module periodic_lattice_neighbor_index_unit_tb;

	localparam int LATENCY = plni_pkg::PIPE_STAGES;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic              by_coords;
		logic [plni_pkg::SITE_W-1:0] site;
		logic [plni_pkg::COORD_W-1:0] cx, cy, cz, ct;
		logic signed [plni_pkg::SHIFT_W-1:0] sx, sy, sz, st;
	} lattice_req_t;

	typedef struct packed {
		logic [plni_pkg::SITE_W-1:0]  index;
		logic [plni_pkg::COORD_W-1:0] nx, ny, nz, nt;
		logic               outside;
	} lattice_res_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [1:0] cfg_index;
	logic [plni_pkg::EXT_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [plni_pkg::IN_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [plni_pkg::OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	// Extents as the predictor sees them, raw register values.
	logic [plni_pkg::EXT_W-1:0] extent [plni_pkg::AXES];

	lattice_req_t pending_reqs [$];
	lattice_res_t expected_sites [$];
	int send_idle_pct;
	int recv_stall_pct;
	bit failed;
	bit in_fire;
	int unsigned cycle_count;

	periodic_lattice_neighbor_index_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// An extent register of zero behaves as one, and anything above the
	// maximum behaves as the maximum.
	function automatic int unsigned usable_extent(logic [plni_pkg::EXT_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > 64) return 64;
		return raw;
	endfunction

	// Adds the shift, flags a shift wider than the extent and wraps fully.
	function automatic int unsigned wrap_shifted(int unsigned c,
			logic signed [plni_pkg::SHIFT_W-1:0] s, int unsigned e, ref logic outside);
		int ei;
		int r;
		ei = e;
		if (int'(s) < -ei || int'(s) > ei) outside = 1'b1;
		r = (int'(c) + int'(s)) % ei;
		if (r < 0) r += ei;
		return r;
	endfunction

	function automatic lattice_res_t neighbour_site(lattice_req_t q);
		lattice_res_t res;
		int unsigned e [plni_pkg::AXES];
		int unsigned c [plni_pkg::AXES];
		int unsigned r [plni_pkg::AXES];
		longint unsigned plane, cube, vol, site, idx;
		logic outside;
		logic [plni_pkg::COORD_W-1:0] raw_c [plni_pkg::AXES];
		outside = 1'b0;
		for (int a = 0; a < plni_pkg::AXES; a++) e[a] = usable_extent(extent[a]);
		plane = e[0] * e[1];
		cube = plane * e[2];
		vol = cube * e[3];
		if (!q.by_coords) begin
			site = q.site;
			if (site >= vol) begin
				outside = 1'b1;
				site = site % vol;
			end
			c[0] = site % e[0];
			c[1] = (site % plane) / e[0];
			c[2] = (site % cube) / plane;
			c[3] = site / cube;
		end else begin
			raw_c[0] = q.cx; raw_c[1] = q.cy; raw_c[2] = q.cz; raw_c[3] = q.ct;
			for (int a = 0; a < plni_pkg::AXES; a++) begin
				c[a] = raw_c[a];
				if (c[a] >= e[a]) begin
					outside = 1'b1;
					c[a] = c[a] % e[a];
				end
			end
		end
		r[0] = wrap_shifted(c[0], q.sx, e[0], outside);
		r[1] = wrap_shifted(c[1], q.sy, e[1], outside);
		r[2] = wrap_shifted(c[2], q.sz, e[2], outside);
		r[3] = wrap_shifted(c[3], q.st, e[3], outside);
		idx = r[0] + r[1] * e[0] + r[2] * plane + r[3] * cube;
		res.index = idx[plni_pkg::SITE_W-1:0];
		res.nx = r[0]; res.ny = r[1]; res.nz = r[2]; res.nt = r[3];
		res.outside = outside;
		return res;
	endfunction

	// Driver: presents the oldest pending request and holds it until it is taken, and drives m_tready at random.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!s_tvalid || in_fire) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_reqs[0].by_coords;
					s_tdata <= {pending_reqs[0].st, pending_reqs[0].sz, pending_reqs[0].sy,
						pending_reqs[0].sx, pending_reqs[0].ct, pending_reqs[0].cz,
						pending_reqs[0].cy, pending_reqs[0].cx, pending_reqs[0].site};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Acceptance is taken at the rising edge, the same edge the block sees.
	always @(posedge clk) begin
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			expected_sites.push_back(neighbour_site(pending_reqs.pop_front()));
		end
	end

	// Monitor: compares each result with the oldest expectation.
	always @(posedge clk) begin
		lattice_res_t got;
		lattice_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[plni_pkg::SITE_W-1:0],
				m_tdata[plni_pkg::SITE_W +: plni_pkg::COORD_W],
				m_tdata[plni_pkg::SITE_W+plni_pkg::COORD_W +: plni_pkg::COORD_W],
				m_tdata[plni_pkg::SITE_W+2*plni_pkg::COORD_W +: plni_pkg::COORD_W],
				m_tdata[plni_pkg::SITE_W+3*plni_pkg::COORD_W +: plni_pkg::COORD_W], m_tuser};
			if (expected_sites.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				failed = 1'b1;
			end else begin
				want = expected_sites.pop_front();
				if (got.index !== want.index)
					$display("%0t: new_index expected %0d actual %0d", $time, want.index, got.index);
				if (got.nx !== want.nx)
					$display("%0t: new_x expected %0d actual %0d", $time, want.nx, got.nx);
				if (got.ny !== want.ny)
					$display("%0t: new_y expected %0d actual %0d", $time, want.ny, got.ny);
				if (got.nz !== want.nz)
					$display("%0t: new_z expected %0d actual %0d", $time, want.nz, got.nz);
				if (got.nt !== want.nt)
					$display("%0t: new_t expected %0d actual %0d", $time, want.nt, got.nt);
				if (got.outside !== want.outside)
					$display("%0t: out_of_range expected %0b actual %0b", $time,
						want.outside, got.outside);
				if (got !== want) failed = 1'b1;
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Waits until every request has been taken and every result has arrived.
	task automatic drain();
		while (pending_reqs.size() != 0 || expected_sites.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Configuration writes go out only while the unit is drained.
	task automatic write_extent(plni_pkg::reg_idx_t which,
			logic [plni_pkg::EXT_W-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		extent[which] = value;
	endtask

	task automatic set_lattice(logic [plni_pkg::EXT_W-1:0] ex, logic [plni_pkg::EXT_W-1:0] ey,
			logic [plni_pkg::EXT_W-1:0] ez, logic [plni_pkg::EXT_W-1:0] et);
		write_extent(plni_pkg::REG_EXTENT_X, ex);
		write_extent(plni_pkg::REG_EXTENT_Y, ey);
		write_extent(plni_pkg::REG_EXTENT_Z, ez);
		write_extent(plni_pkg::REG_EXTENT_T, et);
	endtask

	// A shift that mostly stays within the extent, sometimes beyond it,
	// and now and then any byte at all.
	function automatic logic signed [plni_pkg::SHIFT_W-1:0] pick_shift(int unsigned e);
		int k;
		k = $urandom_range(99);
		if (k < 80) return $signed($urandom_range(2 * e)) - $signed(e);
		if (k < 90) return (k & 1) ? e + 1 + $urandom_range(8) : -(e + 1 + $urandom_range(8));
		return $urandom;
	endfunction

	function automatic lattice_req_t random_request();
		lattice_req_t q;
		int unsigned e [plni_pkg::AXES];
		longint unsigned vol;
		for (int a = 0; a < plni_pkg::AXES; a++) e[a] = usable_extent(extent[a]);
		vol = e[0] * e[1] * e[2] * e[3];
		q = '0;
		q.by_coords = $urandom_range(1);
		// Unused fields still carry noise, so they are seen to be ignored.
		q.site = $urandom;
		q.cx = $urandom; q.cy = $urandom; q.cz = $urandom; q.ct = $urandom;
		if ($urandom_range(9) < 8) begin
			q.site = $urandom % vol;
			q.cx = $urandom_range(e[0] - 1);
			q.cy = $urandom_range(e[1] - 1);
			q.cz = $urandom_range(e[2] - 1);
			q.ct = $urandom_range(e[3] - 1);
		end
		q.sx = pick_shift(e[0]);
		q.sy = pick_shift(e[1]);
		q.sz = pick_shift(e[2]);
		q.st = pick_shift(e[3]);
		return q;
	endfunction

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) pending_reqs.push_back(random_request());
	endtask

	// Runs a batch split across the four idling styles.
	task automatic run_batch(int count);
		send_idle_pct = 0; recv_stall_pct = 0;
		queue_random(count / 4); drain();
		send_idle_pct = 53; recv_stall_pct = 0;
		queue_random(count / 4); drain();
		send_idle_pct = 0; recv_stall_pct = 53;
		queue_random(count / 4); drain();
		send_idle_pct = 26; recv_stall_pct = 26;
		queue_random(count / 4); drain();
	endtask

	initial begin
		lattice_req_t q;
		failed = 1'b0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_wen = 1'b0;
		cfg_index = plni_pkg::REG_EXTENT_X;
		cfg_wdata = '0;
		for (int a = 0; a < plni_pkg::AXES; a++) extent[a] = plni_pkg::EXT_RESET;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests on the reset lattice of sixteen per side.
		q = '0;
		pending_reqs.push_back(q);
		q.site = 24'hFFFFFF; pending_reqs.push_back(q);
		q.site = 65535; q.sx = 1; q.sy = 1; q.sz = 1; q.st = 1; pending_reqs.push_back(q);
		q.site = 0; q.sx = -16; q.sy = 16; q.sz = -16; q.st = 16; pending_reqs.push_back(q);
		q.sx = 8'sh7F; q.sy = -128; q.sz = 17; q.st = -17; pending_reqs.push_back(q);
		q = '0; q.by_coords = 1'b1;
		q.cx = 15; q.cy = 15; q.cz = 15; q.ct = 15; q.site = 24'hFFFFFF;
		pending_reqs.push_back(q);
		q.cx = 63; q.cy = 16; q.cz = 0; q.ct = 42; q.sx = -1; pending_reqs.push_back(q);
		q.cx = 0; q.cy = 0; q.cz = 0; q.ct = 0; q.sx = -1; q.sy = -1; q.sz = -1; q.st = -1;
		pending_reqs.push_back(q);
		q.sx = -128; q.sy = 8'sh7F; q.sz = 64; q.st = -64; pending_reqs.push_back(q);
		drain();

		// Extremes: zero registers count as one, oversized ones as the maximum.
		set_lattice(0, 0, 0, 0);
		q = '0; q.site = 5; pending_reqs.push_back(q);
		q.by_coords = 1'b1; q.cx = 63; q.sx = 1; pending_reqs.push_back(q);
		drain();
		set_lattice(7'd127, 7'd64, 7'd65, 7'd64);
		q = '0; q.site = 24'hFFFFFF; q.sx = 64; q.st = -64; pending_reqs.push_back(q);
		q.by_coords = 1'b1; q.cx = 63; q.cy = 63; q.cz = 63; q.ct = 63;
		q.sx = 1; q.sy = 1; q.sz = 1; q.st = 1; pending_reqs.push_back(q);
		drain();
		run_batch(160);

		set_lattice(1, 1, 1, 1);
		run_batch(120);
		set_lattice(3, 5, 7, 2);
		run_batch(240);
		set_lattice(16, 16, 16, 16);
		run_batch(200);
		set_lattice(64, 1, 37, 9);
		run_batch(160);
		set_lattice(11, 64, 2, 64);
		run_batch(200);

		drain();
		if (!failed) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
